[sv/gblur_pkg.sv]
// ----------------------------------------------------------------------------
// gblur_pkg: shared types and constants for the 3x3 Gaussian blur stream
// Field widths, register indexes, reset values and the stage-1 control bundle.
// ----------------------------------------------------------------------------
package gblur_pkg;

    // fixed field widths
    localparam int ROW_BITS       = 16;
    localparam int COL_OUT_BITS   = 10;
    localparam int CFG_WIDTH_BITS = 11;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_IDX_BITS   = 1;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_HEIGHT = 1'b1;

    // register reset values
    localparam int WIDTH_RESET  = 1024;
    localparam int HEIGHT_RESET = 1;

    // result queue
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = 4;
    localparam int FIFO_CW    = 5;
    localparam int MAX_RESULTS = 4;

    // control flags travelling with a pixel into stage 1
    typedef struct packed {
        logic fwd;       // same line-store entry written in the previous cycle
        logic r_ge1;     // row >= 1
        logic c_ge1;     // column >= 1
        logic inner;     // row >= 2 and column >= 2: result at (r-1,c-1) is interior
        logic row_end;   // last column of the row
        logic last_row;  // last row of the frame
    } s1_ctl_t;

endpackage

[sv/gblur_ram.sv]
// ----------------------------------------------------------------------------
// gblur_ram: generic single-clock RAM
// One write port, one read port, registered read data (read-before-write).
// ----------------------------------------------------------------------------
module gblur_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/gaussian_blur_3x3_stream.sv]
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_stream: streaming 3x3 Gaussian blur (1,2,1 kernel)
// Raster-order pixels in, U(PIXEL_BITS).4 results out one row and one pixel
// behind; border pixels pass through scaled by 16.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata: pixel_in
// m_*       out  m_tvalid/m_tready  m_tdata: pixel_out, out_row, out_col;
//                                   m_tlast: last_of_run; m_tuser: end_of_frame
// cfg_*     in   cfg_we             cfg_idx: register index, cfg_wdata: value
//
// Rate: one pixel per clock while m_tready stays high and each pixel releases
//   at most one result; otherwise the output port (one result per clock) sets
//   the pace, e.g. on the last row.
// Pipeline: stage 0 reads both line stores at the column, stage 1 updates the
//   window, writes the line stores back and pushes up to 4 results into a
//   16-entry result queue. s_tready drops when the queue lacks room for the
//   worst case of the pixel in stage 1 plus the next one.
// Reset: aresetn synchronous, active low; clears counters, pipeline valid and
//   the queue. Line stores are not cleared (never-written entries are unused).
// Stalls: m_tready low only fills the queue; the pipeline itself never stalls.
// ----------------------------------------------------------------------------
module gaussian_blur_3x3_stream #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // config write port
    input  logic                                  cfg_we,
    input  logic [gblur_pkg::CFG_IDX_BITS-1:0]    cfg_idx,
    input  logic [gblur_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    // pixel input
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((PIXEL_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // pixel_in
    // result output
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // pixel_out, out_row, out_col (lowest bit up)
    output logic [((PIXEL_BITS + 4 + gblur_pkg::ROW_BITS + gblur_pkg::COL_OUT_BITS + 7) / 8)
                  * 8 - 1:0]                      m_tdata,
    output logic                                  m_tlast,  // last_of_run
    output logic                                  m_tuser   // end_of_frame
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = PIXEL_BITS + 4;
    localparam int CSW   = PIXEL_BITS + 2;
    localparam int M_DW  = ((RW + gblur_pkg::ROW_BITS + gblur_pkg::COL_OUT_BITS + 7) / 8) * 8;
    localparam int RB    = gblur_pkg::ROW_BITS;
    localparam int COB   = gblur_pkg::COL_OUT_BITS;
    localparam int RST_W = (gblur_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                                : gblur_pkg::WIDTH_RESET;
    localparam int FD    = gblur_pkg::FIFO_DEPTH;
    localparam int FAW   = gblur_pkg::FIFO_AW;
    localparam int FCW   = gblur_pkg::FIFO_CW;
    localparam int NR    = gblur_pkg::MAX_RESULTS;

    // ------------------------------------------------------------------
    // configuration: effective width/height kept as value minus one
    // ------------------------------------------------------------------
    logic [CW-1:0] width_m1_reg, width_m1_next;
    logic [RB-1:0] height_m1_reg, height_m1_next;
    logic [31:0]   w_raw;
    logic [31:0]   w_eff;

    always_comb begin
        w_raw = 32'(cfg_wdata[gblur_pkg::CFG_WIDTH_BITS-1:0]);
        if (w_raw == 32'd0) begin
            w_eff = 32'd1;
        end else if (w_raw > 32'(MAX_WIDTH)) begin
            w_eff = 32'(MAX_WIDTH);
        end else begin
            w_eff = w_raw;
        end
        width_m1_next  = width_m1_reg;
        height_m1_next = height_m1_reg;
        if (cfg_we) begin
            case (cfg_idx)
                gblur_pkg::CFG_IDX_WIDTH: begin
                    width_m1_next = CW'(w_eff - 32'd1);
                end
                gblur_pkg::CFG_IDX_HEIGHT: begin
                    height_m1_next = (cfg_wdata == '0) ? '0 : RB'(cfg_wdata - 1'b1);
                end
                default: begin
                    width_m1_next = width_m1_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_m1_reg  <= CW'(RST_W - 1);
            height_m1_reg <= RB'(gblur_pkg::HEIGHT_RESET - 1);
        end else begin
            width_m1_reg  <= width_m1_next;
            height_m1_reg <= height_m1_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 0: position counters and line-store read
    // ------------------------------------------------------------------
    logic [CW-1:0] col_reg, col_next;
    logic [RB-1:0] row_reg, row_next;
    logic [CW-1:0] c0;
    logic [RB-1:0] r0;
    logic          row_end0, last_row0;
    logic          s_accept;
    logic [PIXEL_BITS-1:0] px0;

    assign s_accept = s_tvalid && s_tready;
    assign px0      = s_tdata[PIXEL_BITS-1:0];

    always_comb begin
        c0        = (col_reg > width_m1_reg) ? width_m1_reg : col_reg;
        r0        = (row_reg > height_m1_reg) ? height_m1_reg : row_reg;
        row_end0  = (c0 == width_m1_reg);
        last_row0 = (r0 == height_m1_reg);
        col_next  = col_reg;
        row_next  = row_reg;
        if (cfg_we) begin
            // any register write restarts the frame
            col_next = '0;
            row_next = '0;
        end else if (s_accept) begin
            if (row_end0) begin
                col_next = '0;
                row_next = last_row0 ? '0 : RB'(r0 + 1'b1);
            end else begin
                col_next = CW'(c0 + 1'b1);
                row_next = r0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 1 registers
    // ------------------------------------------------------------------
    logic                  s1_valid_reg;
    gblur_pkg::s1_ctl_t    s1_ctl_reg;
    logic [CW-1:0]         s1_c_reg;
    logic [RB-1:0]         s1_r_reg;
    logic [PIXEL_BITS-1:0] s1_px_reg;
    logic [PIXEL_BITS-1:0] s1_fwd_a_reg, s1_fwd_b_reg;
    logic [PIXEL_BITS-1:0] rd_a, rd_b;
    logic [PIXEL_BITS-1:0] a_eff, b_eff;

    // line store a: row above; line store b: two rows above
    gblur_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_line_a (
        .aclk  (aclk),
        .we    (s1_valid_reg),
        .waddr (s1_c_reg),
        .wdata (s1_px_reg),
        .raddr (c0),
        .rdata (rd_a)
    );

    gblur_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_line_b (
        .aclk  (aclk),
        .we    (s1_valid_reg),
        .waddr (s1_c_reg),
        .wdata (a_eff),
        .raddr (c0),
        .rdata (rd_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s_accept;
        end
    end

    // the read in stage 0 misses a write-back issued in the same cycle to the
    // same entry (only at width one); forward what that write carries
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_ctl_reg.fwd      <= s1_valid_reg && (s1_c_reg == c0);
            s1_ctl_reg.r_ge1    <= (r0 != '0);
            s1_ctl_reg.c_ge1    <= (c0 != '0);
            s1_ctl_reg.inner    <= (r0 > RB'(1)) && (c0 > CW'(1));
            s1_ctl_reg.row_end  <= row_end0;
            s1_ctl_reg.last_row <= last_row0;
            s1_c_reg            <= c0;
            s1_r_reg            <= r0;
            s1_px_reg           <= px0;
            s1_fwd_a_reg        <= s1_px_reg;
            s1_fwd_b_reg        <= a_eff;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: window update, results
    // window kept as weighted column sums of the two older columns plus the
    // middle and bottom samples of the newest column
    // ------------------------------------------------------------------
    logic [CSW-1:0]        cs1_reg, cs2_reg;
    logic [PIXEL_BITS-1:0] w12_reg, w22_reg;
    logic [CSW-1:0]        cs_new;
    logic [RW-1:0]         blur;

    always_comb begin
        a_eff  = s1_ctl_reg.fwd ? s1_fwd_a_reg : rd_a;
        b_eff  = s1_ctl_reg.fwd ? s1_fwd_b_reg : rd_b;
        cs_new = CSW'(b_eff) + (CSW'(a_eff) << 1) + CSW'(s1_px_reg);
        blur   = RW'(cs1_reg) + (RW'(cs2_reg) << 1) + RW'(cs_new);
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            cs1_reg <= cs2_reg;
            cs2_reg <= cs_new;
            w12_reg <= a_eff;
            w22_reg <= s1_px_reg;
        end
    end

    // candidate results in output order
    logic [NR-1:0]  res_en;
    logic [RW-1:0]  res_pix [NR];
    logic [RB-1:0]  res_row [NR];
    logic [COB-1:0] res_col [NR];
    logic [NR-1:0]  res_last;
    logic [2:0]     res_pos [NR];
    logic [2:0]     push_n;
    logic [RB-1:0]  r_m1;
    logic [CW-1:0]  c_m1;

    always_comb begin
        r_m1 = RB'(s1_r_reg - 1'b1);
        c_m1 = CW'(s1_c_reg - 1'b1);

        // (r-1, c-1): blurred if interior
        res_en[0]  = s1_valid_reg && s1_ctl_reg.r_ge1 && s1_ctl_reg.c_ge1;
        res_pix[0] = s1_ctl_reg.inner ? blur : (RW'(w12_reg) << 4);
        res_row[0] = r_m1;
        res_col[0] = COB'(c_m1);
        // (r-1, c): right border of the row above
        res_en[1]  = s1_valid_reg && s1_ctl_reg.r_ge1 && s1_ctl_reg.row_end;
        res_pix[1] = RW'(a_eff) << 4;
        res_row[1] = r_m1;
        res_col[1] = COB'(s1_c_reg);
        // (r, c-1): bottom border
        res_en[2]  = s1_valid_reg && s1_ctl_reg.last_row && s1_ctl_reg.c_ge1;
        res_pix[2] = RW'(w22_reg) << 4;
        res_row[2] = s1_r_reg;
        res_col[2] = COB'(c_m1);
        // (r, c): bottom right corner, frame end
        res_en[3]  = s1_valid_reg && s1_ctl_reg.last_row && s1_ctl_reg.row_end;
        res_pix[3] = RW'(s1_px_reg) << 4;
        res_row[3] = s1_r_reg;
        res_col[3] = COB'(s1_c_reg);

        res_last[3] = res_en[3];
        res_last[2] = res_en[2] && !res_en[3];
        res_last[1] = res_en[1] && !(|res_en[3:2]);
        res_last[0] = res_en[0] && !(|res_en[3:1]);

        res_pos[0] = 3'd0;
        res_pos[1] = 3'(res_en[0]);
        res_pos[2] = res_pos[1] + 3'(res_en[1]);
        res_pos[3] = res_pos[2] + 3'(res_en[2]);
        push_n     = res_pos[3] + 3'(res_en[3]);
    end

    // ------------------------------------------------------------------
    // result queue: up to four pushes, one pop per cycle
    // ------------------------------------------------------------------
    logic [RW-1:0]  q_pix  [FD];
    logic [RB-1:0]  q_row  [FD];
    logic [COB-1:0] q_col  [FD];
    logic           q_last [FD];
    logic           q_eof  [FD];
    logic [FAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FCW-1:0] cnt_reg, cnt_next;
    logic           m_pop;
    logic [FCW:0]   room_need;

    assign m_tvalid = (cnt_reg != '0);
    assign m_pop    = m_tvalid && m_tready;

    // room for the pixel now in stage 1 and the one about to enter
    assign room_need = (FCW + 1)'(cnt_reg) + (s1_valid_reg ? (FCW + 1)'(NR) : '0);
    assign s_tready  = (room_need <= (FCW + 1)'(FD - NR));

    always_comb begin
        wr_ptr_next = FAW'(wr_ptr_reg + push_n);
        rd_ptr_next = m_pop ? FAW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        cnt_next    = FCW'(cnt_reg + push_n - (m_pop ? 1'b1 : 1'b0));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NR; k++) begin
            if (res_en[k]) begin
                q_pix [FAW'(wr_ptr_reg + res_pos[k])] <= res_pix[k];
                q_row [FAW'(wr_ptr_reg + res_pos[k])] <= res_row[k];
                q_col [FAW'(wr_ptr_reg + res_pos[k])] <= res_col[k];
                q_last[FAW'(wr_ptr_reg + res_pos[k])] <= res_last[k];
                q_eof [FAW'(wr_ptr_reg + res_pos[k])] <= (k == NR - 1);
            end
        end
    end

    assign m_tdata = M_DW'({q_col[rd_ptr_reg], q_row[rd_ptr_reg], q_pix[rd_ptr_reg]});
    assign m_tlast = q_last[rd_ptr_reg];
    assign m_tuser = q_eof[rd_ptr_reg];

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a push never overruns the queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> (32'(cnt_reg) + 32'(push_n) - 32'(m_pop)) <= 32'(FD))
        else $error("result queue overflow");

    // forwarding only happens when one column per row hits the same entry
    a_fwd_width_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_ctl_reg.fwd) |-> (width_m1_reg == '0))
        else $error("line store forward outside width one");

    // the frame-end result closes its run
    a_eof_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("end_of_frame without last_of_run");

    // results are pushed only from stage 1, for a pixel that was accepted
    a_push_from_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_n != 3'd0) |-> $past(s_accept))
        else $error("results pushed without an accepted pixel");

    // a pixel past column zero or at a row end, on any row but the first, always releases at least one result
    a_row_gt0_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_ctl_reg.r_ge1 && (s1_ctl_reg.c_ge1 || s1_ctl_reg.row_end))
        |-> (push_n != 3'd0))
        else $error("pixel released no result");

endmodule

[tb/gaussian_blur_3x3_stream_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_stream_test: self-checking bench for the 3x3 blur stream
// Feeds raster frames of varied size through the pixel stream, predicts every
// blurred or passed-through result in-bench and checks each output transaction
// in order. Random idle gaps on both sides, a long output hold-off that backs
// the block up, and register writes between drained phases.
// ----------------------------------------------------------------------------
module gaussian_blur_3x3_stream_test;

    localparam int MAX_W          = 1024;
    localparam int PIX_W          = 16;
    localparam int ROW_W          = gblur_pkg::ROW_BITS;
    localparam int COL_W          = gblur_pkg::COL_OUT_BITS;
    localparam int OUT_BITS       = ((PIX_W + 4 + ROW_W + COL_W + 7) / 8) * 8;
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 8;     // pipeline is 2 deep; give it margin
    localparam int LONG_HOLD      = 400;   // output hold-off, in cycles
    localparam int STALL_LIMIT    = 2000;  // cycles without any transaction or register write
    localparam int PRESSURE_ITEMS = 96;    // pixels sent against the hold-off
    localparam int RANDOM_ITEMS   = 240;
    localparam int MAX_AREA       = 240;   // keep random frames short

    // one result transaction as the bench sees it
    typedef struct packed {
        logic [PIX_W+3:0] pix;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
        logic             eof;
    } result_t;

    typedef enum logic [1:0] {STIM_PIXEL, STIM_WIDTH, STIM_HEIGHT} stim_kind_t;

    // directed row: a pixel or a register write; typed rows carry their
    // single result written out by hand
    typedef struct packed {
        stim_kind_t   kind;
        logic [15:0]  value;
        logic         typed;
        result_t      res;
    } stim_t;

    localparam result_t NO_RESULT = '0;

    localparam stim_t DIRECTED [29] = '{
        // reset setting: 1024 wide, 1 row, so every pixel is on the last row
        '{STIM_PIXEL,  16'hFFFF, 1'b0, NO_RESULT},
        '{STIM_PIXEL,  16'h0000, 1'b1, '{20'hFFFF0, 16'd0, 10'd0, 1'b1, 1'b0}},
        '{STIM_PIXEL,  16'h1234, 1'b1, '{20'h00000, 16'd0, 10'd1, 1'b1, 1'b0}},
        // zero width and height behave as a 1x1 frame; frames wrap
        '{STIM_WIDTH,  16'd0,    1'b0, NO_RESULT},
        '{STIM_HEIGHT, 16'd0,    1'b0, NO_RESULT},
        '{STIM_PIXEL,  16'h8001, 1'b1, '{20'h80010, 16'd0, 10'd0, 1'b1, 1'b1}},
        '{STIM_PIXEL,  16'hFFFF, 1'b1, '{20'hFFFF0, 16'd0, 10'd0, 1'b1, 1'b1}},
        // smallest frame with an interior pixel
        '{STIM_WIDTH,  16'd3,    1'b0, NO_RESULT},
        '{STIM_HEIGHT, 16'd3,    1'b0, NO_RESULT},
        '{STIM_PIXEL,  16'hFFFF, 1'b0, NO_RESULT},
        '{STIM_PIXEL,  16'h0001, 1'b0, NO_RESULT},
        '{STIM_PIXEL,  16'hFFFF, 1'b0, NO_RESULT},
        '{STIM_PIXEL,  16'h8000, 1'b0, NO_RESULT},
        '{STIM_PIXEL,  16'hFFFF, 1'b0, NO_RESULT},
        '{STIM_PIXEL,  16'h7FFF, 1'b0, NO_RESULT},
        '{STIM_PIXEL,  16'hFFFF, 1'b0, NO_RESULT},
        '{STIM_PIXEL,  16'h0000, 1'b0, NO_RESULT},
        '{STIM_PIXEL,  16'hFFFF, 1'b0, NO_RESULT},
        // 2x2: border only
        '{STIM_WIDTH,  16'd2,    1'b0, NO_RESULT},
        '{STIM_HEIGHT, 16'd2,    1'b0, NO_RESULT},
        '{STIM_PIXEL,  16'h0011, 1'b0, NO_RESULT},
        '{STIM_PIXEL,  16'h0022, 1'b0, NO_RESULT},
        '{STIM_PIXEL,  16'h0033, 1'b0, NO_RESULT},
        '{STIM_PIXEL,  16'h0044, 1'b0, NO_RESULT},
        // single column, three rows
        '{STIM_WIDTH,  16'd1,    1'b0, NO_RESULT},
        '{STIM_HEIGHT, 16'd3,    1'b0, NO_RESULT},
        '{STIM_PIXEL,  16'hA5A5, 1'b0, NO_RESULT},
        '{STIM_PIXEL,  16'h5A5A, 1'b0, NO_RESULT},
        '{STIM_PIXEL,  16'hC3C3, 1'b0, NO_RESULT}
    };

    logic                                 aclk;
    logic                                 aresetn;
    logic                                 cfg_we;
    logic [gblur_pkg::CFG_IDX_BITS-1:0]   cfg_idx;
    logic [gblur_pkg::CFG_DATA_BITS-1:0]  cfg_wdata;
    logic                                 s_tvalid;
    logic                                 s_tready;
    logic [PIX_W-1:0]                     s_tdata;   // pixel_in
    logic                                 m_tvalid;
    logic                                 m_tready;
    logic [OUT_BITS-1:0]                  m_tdata;   // pixel_out, out_row, out_col
    logic                                 m_tlast;   // last_of_run
    logic                                 m_tuser;   // end_of_frame

    gaussian_blur_3x3_stream dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Blur predictor: own copy of the line stores, window, position and
    // frame registers. Never-written store entries read as zero; they cannot
    // reach a result, so the value is irrelevant.
    // ------------------------------------------------------------------------
    logic [PIX_W-1:0] one_row_up  [MAX_W];
    logic [PIX_W-1:0] two_rows_up [MAX_W];
    logic [PIX_W-1:0] win [3][3];
    int unsigned      pos_row = 0;
    int unsigned      pos_col = 0;
    int unsigned      frame_w = gblur_pkg::WIDTH_RESET;
    int unsigned      frame_h = gblur_pkg::HEIGHT_RESET;
    result_t          released [gblur_pkg::MAX_RESULTS];   // results of the latest pixel
    result_t          blurred_due [$];                     // results still to arrive
    int               mismatches = 0;

    // driver-owned knobs; the last two are read by the output side
    bit               sender_calm = 1'b0;
    bit               sink_calm   = 1'b0;
    bit               hold_req    = 1'b0;

    initial begin
        foreach (one_row_up[i]) begin
            one_row_up[i]  = '0;
            two_rows_up[i] = '0;
        end
        foreach (win[i, j]) win[i][j] = '0;
    end

    function automatic int unsigned cols_in_use();
        if (frame_w == 0) return 1;
        return (frame_w > MAX_W) ? MAX_W : frame_w;
    endfunction

    function automatic int unsigned rows_in_use();
        return (frame_h == 0) ? 1 : frame_h;
    endfunction

    function automatic result_t make_result(input int unsigned pix, input int unsigned row,
                                            input int unsigned col, input bit eof);
        result_t res;
        res.pix  = (PIX_W + 4)'(pix);
        res.row  = ROW_W'(row);
        res.col  = COL_W'(col);
        res.last = 1'b0;
        res.eof  = eof;
        return res;
    endfunction

    // Advance the model by one pixel; fills released[] and returns the count.
    function automatic int blur_predict(input logic [PIX_W-1:0] px);
        int unsigned w, h, r, c, s;
        int          n;
        bit          row_end, last_row, inner;
        w = cols_in_use();
        h = rows_in_use();
        r = (pos_row >= h) ? h - 1 : pos_row;
        c = (pos_col >= w) ? w - 1 : pos_col;
        row_end  = (c == w - 1);
        last_row = (r == h - 1);
        n = 0;
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = two_rows_up[c];
        win[1][2] = one_row_up[c];
        win[2][2] = px;
        two_rows_up[c] = one_row_up[c];
        one_row_up[c]  = px;
        // row above: the pixel left of this column, plus the row end
        if (r >= 1) begin
            if (c >= 1) begin
                inner = (r >= 2) && (r + 1 <= h) && (c >= 2) && (c + 1 <= w);
                if (inner)
                    s = win[0][0] + 2 * win[0][1] + win[0][2]
                      + 2 * win[1][0] + 4 * win[1][1] + 2 * win[1][2]
                      + win[2][0] + 2 * win[2][1] + win[2][2];
                else
                    s = 32'({win[1][1], 4'b0000});
                released[n] = make_result(s, r - 1, c - 1, 1'b0);
                n++;
            end
            if (row_end) begin
                released[n] = make_result(32'({win[1][2], 4'b0000}), r - 1, c, 1'b0);
                n++;
            end
        end
        // bottom row has no row below, so it drains as it arrives
        if (last_row) begin
            if (c >= 1) begin
                released[n] = make_result(32'({win[2][1], 4'b0000}), r, c - 1, 1'b0);
                n++;
            end
            if (row_end) begin
                released[n] = make_result(32'({win[2][2], 4'b0000}), r, c, 1'b1);
                n++;
            end
        end
        if (n > 0) released[n-1].last = 1'b1;
        if (row_end) begin
            pos_col = 0;
            pos_row = last_row ? 0 : r + 1;
        end else begin
            pos_col = c + 1;
            pos_row = r;
        end
        return n;
    endfunction

    function automatic int pick_gap(input bit calm);
        int roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [PIX_W-1:0] random_pixel();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        return PIX_W'($urandom);
    endfunction

    // ------------------------------------------------------------------------
    // Input side. Each pixel transaction is predicted the step it is taken;
    // s_tvalid only drops when a gap follows, so back-to-back items never see
    // two updates in one step.
    // ------------------------------------------------------------------------
    task automatic send_pixel(input logic [PIX_W-1:0] px, input bit typed,
                              input result_t typed_res);
        int n, gap;
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        n = blur_predict(px);
        if (typed)
            blurred_due.push_back(typed_res);
        else
            for (int i = 0; i < n; i++) blurred_due.push_back(released[i]);
        gap = pick_gap(sender_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stop sending, let every result out, then let the pipeline empty of
    // pixels that release nothing.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (blurred_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register write; the block restarts its frame on any write.
    task automatic write_reg(input logic [gblur_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [gblur_pkg::CFG_DATA_BITS-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx == gblur_pkg::CFG_IDX_WIDTH)
            frame_w = 32'(val & 16'h07FF);
        else
            frame_h = 32'(val);
        pos_row = 0;
        pos_col = 0;
    endtask

    initial begin : stimulus
        int random_sent, roll, w, h, px_count;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_idx   <= gblur_pkg::CFG_IDX_WIDTH;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        foreach (DIRECTED[k]) begin
            case (DIRECTED[k].kind)
                STIM_PIXEL: begin
                    send_pixel(DIRECTED[k].value, DIRECTED[k].typed, DIRECTED[k].res);
                end
                STIM_WIDTH: begin
                    wait_idle();
                    write_reg(gblur_pkg::CFG_IDX_WIDTH, DIRECTED[k].value);
                end
                default: begin
                    wait_idle();
                    write_reg(gblur_pkg::CFG_IDX_HEIGHT, DIRECTED[k].value);
                end
            endcase
        end

        // Wide row with junk above bit 10 of the width write (saturates to
        // the maximum), cut short. The sender runs flat out while the output
        // side takes its long hold-off, so the result queue fills and
        // s_tready has to drop.
        wait_idle();
        write_reg(gblur_pkg::CFG_IDX_HEIGHT, 16'd1);
        write_reg(gblur_pkg::CFG_IDX_WIDTH, 16'hFFFF);
        sender_calm = 1'b1;
        hold_req    = 1'b1;
        repeat (PRESSURE_ITEMS) send_pixel(random_pixel(), 1'b0, NO_RESULT);
        sender_calm = 1'b0;

        // tallest frame, cut short; the next write restarts it
        wait_idle();
        write_reg(gblur_pkg::CFG_IDX_WIDTH, 16'd3);
        write_reg(gblur_pkg::CFG_IDX_HEIGHT, 16'hFFFF);
        repeat (40) send_pixel(random_pixel(), 1'b0, NO_RESULT);

        // random frames: mostly whole frames (one or two), some cut short
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            wait_idle();
            sender_calm = ($urandom_range(0, 5) == 0);
            sink_calm   = ($urandom_range(0, 5) == 0);
            roll = $urandom_range(0, 99);
            w = (roll < 10) ? 0 : (roll < 85) ? $urandom_range(1, 16) : $urandom_range(17, 80);
            roll = $urandom_range(0, 99);
            h = (roll < 12) ? 0 : (roll < 85) ? $urandom_range(1, 8) : $urandom_range(9, 24);
            case ($urandom_range(0, 3))
                0: begin
                    write_reg(gblur_pkg::CFG_IDX_WIDTH, {5'($urandom), 11'(w)});
                end
                1: begin
                    write_reg(gblur_pkg::CFG_IDX_HEIGHT, 16'(h));
                end
                2: begin
                    write_reg(gblur_pkg::CFG_IDX_HEIGHT, 16'(h));
                    write_reg(gblur_pkg::CFG_IDX_WIDTH, {5'($urandom), 11'(w)});
                end
                default: begin
                    write_reg(gblur_pkg::CFG_IDX_WIDTH, {5'($urandom), 11'(w)});
                    write_reg(gblur_pkg::CFG_IDX_HEIGHT, 16'(h));
                end
            endcase
            if (cols_in_use() * rows_in_use() > MAX_AREA)
                write_reg(gblur_pkg::CFG_IDX_HEIGHT, 16'(MAX_AREA / cols_in_use()));
            px_count = cols_in_use() * rows_in_use();
            if ($urandom_range(0, 4) == 0 && px_count > 1)
                px_count = $urandom_range(1, px_count - 1);
            else
                px_count = px_count * $urandom_range(1, 2);
            if (px_count > RANDOM_ITEMS - random_sent)
                px_count = RANDOM_ITEMS - random_sent;
            repeat (px_count) begin
                send_pixel(random_pixel(), 1'b0, NO_RESULT);
                random_sent++;
            end
        end

        wait_idle();
        if (mismatches == 0 && blurred_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Output side: random m_tready with one long hold-off when asked for.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int  gap;
        bit  hold_taken;
        hold_taken = 1'b0;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                gap = pick_gap(sink_calm);
                if (gap == 0) begin
                    m_tready <= 1'b1;
                    @(posedge aclk);
                end else begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    // Each result transaction against the oldest expectation, field by field.
    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (blurred_due.size() == 0) begin
                $error("unexpected result transaction: tdata %h", m_tdata);
                mismatches++;
            end else begin
                want = blurred_due.pop_front();
                if (m_tdata[PIX_W+3:0] !== want.pix) begin
                    $error("pixel_out: expected %0d, got %0d", want.pix, m_tdata[PIX_W+3:0]);
                    mismatches++;
                end
                if (m_tdata[PIX_W+4 +: ROW_W] !== want.row) begin
                    $error("out_row: expected %0d, got %0d", want.row,
                           m_tdata[PIX_W+4 +: ROW_W]);
                    mismatches++;
                end
                if (m_tdata[PIX_W+4+ROW_W +: COL_W] !== want.col) begin
                    $error("out_col: expected %0d, got %0d", want.col,
                           m_tdata[PIX_W+4+ROW_W +: COL_W]);
                    mismatches++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_of_run: expected %0d, got %0d", want.last, m_tlast);
                    mismatches++;
                end
                if (m_tuser !== want.eof) begin
                    $error("end_of_frame: expected %0d, got %0d", want.eof, m_tuser);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: too long without any transaction or register write ends the run.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[gaussian_blur_3x3_stream.f]
sv/gblur_pkg.sv
sv/gblur_ram.sv
sv/gaussian_blur_3x3_stream.sv
tb/gaussian_blur_3x3_stream_test.sv
